>>> hw/rtl/dtt_pkg.sv
// Package for the deadline timer table: request/response types, slot entry
// layout, command and status codes, and the saturating add helper.
// No dependencies.
package dtt_pkg;

  localparam int SLOTS_DEFAULT    = 32;
  localparam int MAX_USABLE       = 32;
  localparam logic [31:0] ROLLOVER_RESET  = 32'd3600000;  // one hour in ms
  localparam logic [31:0] IDLE_WAIT_RESET = 32'd1000;

  // command codes
  localparam logic [2:0] CMD_ADD     = 3'd0;
  localparam logic [2:0] CMD_CANCEL  = 3'd1;
  localparam logic [2:0] CMD_REFRESH = 3'd2;
  localparam logic [2:0] CMD_RESET   = 3'd3;
  localparam logic [2:0] CMD_TICK    = 3'd4;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_INACTIVE = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;

  // configuration register indexes
  localparam logic CFG_ROLLOVER  = 1'b0;
  localparam logic CFG_IDLE_WAIT = 1'b1;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [47:0] now_ms;
    logic [4:0]  slot;
    logic [31:0] period_ms;
    logic        repeats;
    logic        rearm_now;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [4:0]  out_slot;
    logic        expired;
    logic [31:0] wait_ms;
    logic        last;
  } rsp_t;

  typedef struct packed {
    logic        recurring;
    logic [31:0] period;
    logic [47:0] deadline;
  } entry_t;

  // 48 + 32 bit add, saturated at 2^48-1
  function automatic logic [47:0] sat_add48(input logic [47:0] a, input logic [31:0] b);
    logic [48:0] s;
    s = {1'b0, a} + {17'b0, b};
    return s[48] ? {48{1'b1}} : s[47:0];
  endfunction

endpackage

>>> hw/rtl/dtt_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dtt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/deadline_timer_table.sv
// Deadline timer table top level: command sequencer, scan unit and slot RAM.
// Depends on dtt_pkg and dtt_ram.
//
//  channel  | signals                     | handshake
//  ---------+-----------------------------+-------------------------------
//  request  | start, busy, req            | taken when start && !busy
//  result   | done, rsp                   | one result per done strobe, no stall
//  config   | cfg_we, cfg_index, cfg_data | written when cfg_we
//
// Add, cancel and unknown commands, and a refresh or reset of a slot out of
// range, answer in the cycle after the request; refresh answers from the op
// state, reset from the op state or, when it rewrites the slot, from the
// second reset state. A tick scans every usable slot through the single RAM
// read port, and runs one scan per expiry plus a final scan for the wait.
// busy stays high until the last result. Reset clears the active bits in
// flops; the slot RAM needs no clearing pass. The receiver cannot stall results.
module deadline_timer_table
  import dtt_pkg::*;
#(
  parameter int SLOTS = SLOTS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  req_t        req,
  output logic        done,
  output rsp_t        rsp,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int NUSE  = (SLOTS > MAX_USABLE) ? MAX_USABLE : SLOTS;
  localparam int IDX_W = $clog2(NUSE);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUSE - 1);

  typedef enum logic [2:0] {S_IDLE, S_OP, S_RST2, S_SCAN, S_DECIDE} state_t;

  state_t            state;
  req_t              cur;
  logic [31:0]       rollover_window;
  logic [31:0]       idle_wait;
  logic [47:0]       previous_now;
  logic [NUSE-1:0]   active;
  logic [NUSE-1:0]   due;
  logic              roll;
  logic              first;
  logic [IDX_W:0]    scn;
  logic              rd_v;
  logic [IDX_W-1:0]  rd_idx;
  logic [47:0]       start_r;
  // best due slot and earliest active deadline of the current scan
  logic              bd_v;
  logic [IDX_W-1:0]  bd_idx;
  logic [47:0]       bd_dl;
  logic [31:0]       bd_per;
  logic              bd_rec;
  logic              ba_v;
  logic [47:0]       ba_dl;

  logic              ram_we;
  logic [IDX_W-1:0]  ram_waddr;
  entry_t            ram_wdata;
  logic [IDX_W-1:0]  ram_raddr;
  entry_t            rd;

  logic [47:0]       add_a;
  logic [31:0]       add_b;
  logic [47:0]       add_sum;
  logic              free_v;
  logic [IDX_W-1:0]  free_idx;
  logic              req_valid;
  logic [IDX_W-1:0]  req_idx;
  logic              cur_valid;
  logic [IDX_W-1:0]  cur_idx;
  logic              rd_due;
  logic [47:0]       wait_diff;
  logic              done_next;
  rsp_t              rsp_next;

  assign busy      = (state != S_IDLE);
  assign req_valid = ({1'b0, req.slot} < 6'(NUSE));
  assign req_idx   = req.slot[IDX_W-1:0];
  assign cur_valid = ({1'b0, cur.slot} < 6'(NUSE));
  assign cur_idx   = cur.slot[IDX_W-1:0];

  dtt_ram #(.WIDTH($bits(entry_t)), .DEPTH(NUSE)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd)
  );

  // lowest free slot
  always_comb begin
    free_v   = 1'b0;
    free_idx = '0;
    for (int i = NUSE - 1; i >= 0; i--) begin
      if (!active[i]) begin
        free_v   = 1'b1;
        free_idx = IDX_W'(i);
      end
    end
  end

  // shared saturating adder operand select
  always_comb begin
    case (state)
      S_OP:     begin add_a = cur.now_ms; add_b = rd.period;     end
      S_RST2:   begin add_a = start_r;    add_b = cur.period_ms; end
      S_DECIDE: begin add_a = cur.now_ms; add_b = bd_per;        end
      default:  begin add_a = req.now_ms; add_b = req.period_ms; end
    endcase
  end
  assign add_sum = sat_add48(add_a, add_b);

  assign ram_raddr = (state == S_SCAN) ? scn[IDX_W-1:0] : req_idx;
  assign rd_due    = first ? (active[rd_idx] && (roll || rd.deadline <= cur.now_ms))
                           : due[rd_idx];
  assign wait_diff = ba_dl - cur.now_ms;

  // RAM write port
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = free_idx;
    ram_wdata = '{recurring: req.repeats, period: req.period_ms, deadline: add_sum};
    case (state)
      S_IDLE: begin
        ram_we = start && (req.cmd == CMD_ADD) && free_v;
      end
      S_OP: begin
        ram_waddr = cur_idx;
        ram_wdata = '{recurring: rd.recurring, period: rd.period, deadline: add_sum};
        ram_we    = (cur.cmd == CMD_REFRESH) && active[cur_idx];
      end
      S_RST2: begin
        ram_waddr = cur_idx;
        ram_wdata = '{recurring: bd_rec, period: cur.period_ms, deadline: add_sum};
        ram_we    = 1'b1;
      end
      S_DECIDE: begin
        ram_waddr = bd_idx;
        ram_wdata = '{recurring: bd_rec, period: bd_per, deadline: add_sum};
        ram_we    = bd_v && bd_rec;
      end
      default: ;
    endcase
  end

  // result strobe and fields for the next cycle
  always_comb begin
    done_next = 1'b0;
    rsp_next  = '{status: ST_OK, out_slot: '0, expired: 1'b0, wait_ms: '0, last: 1'b1};
    case (state)
      S_IDLE: begin
        if (start) begin
          case (req.cmd)
            CMD_ADD: begin
              done_next = 1'b1;
              if (free_v) rsp_next.out_slot = 5'(free_idx);
              else        rsp_next.status   = ST_FULL;
            end
            CMD_CANCEL: begin
              done_next = 1'b1;
              if (!(req_valid && active[req_idx])) rsp_next.status = ST_INACTIVE;
            end
            CMD_REFRESH, CMD_RESET: begin
              if (!req_valid) begin
                done_next       = 1'b1;
                rsp_next.status = ST_INACTIVE;
              end
            end
            CMD_TICK: ;
            default: done_next = 1'b1;
          endcase
        end
      end
      S_OP: begin
        if (cur.cmd == CMD_REFRESH) begin
          done_next = 1'b1;
          if (!active[cur_idx]) rsp_next.status = ST_INACTIVE;
        end else if (cur.period_ms == rd.period && !cur.rearm_now) begin
          done_next = 1'b1;
        end else if (!active[cur_idx]) begin
          done_next       = 1'b1;
          rsp_next.status = ST_INACTIVE;
        end
      end
      S_RST2: done_next = 1'b1;
      S_DECIDE: begin
        done_next = 1'b1;
        if (bd_v) begin
          rsp_next.out_slot = 5'(bd_idx);
          rsp_next.expired  = 1'b1;
          rsp_next.last     = 1'b0;
        end else begin
          if (!ba_v)                    rsp_next.wait_ms = idle_wait;
          else if (cur.now_ms >= ba_dl) rsp_next.wait_ms = '0;
          else if (|wait_diff[47:32])   rsp_next.wait_ms = '1;
          else                          rsp_next.wait_ms = wait_diff[31:0];
        end
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      done            <= 1'b0;
      active          <= '0;
      previous_now    <= '0;
      rollover_window <= ROLLOVER_RESET;
      idle_wait       <= IDLE_WAIT_RESET;
      rd_v            <= 1'b0;
    end else begin
      done <= done_next;
      rsp  <= rsp_next;
      if (cfg_we) begin
        if (cfg_index == CFG_ROLLOVER) rollover_window <= cfg_data;
        else                           idle_wait       <= cfg_data;
      end
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= req;
            case (req.cmd)
              CMD_ADD: begin
                if (free_v) active[free_idx] <= 1'b1;
              end
              CMD_CANCEL: begin
                if (req_valid && active[req_idx]) active[req_idx] <= 1'b0;
              end
              CMD_REFRESH, CMD_RESET: begin
                if (req_valid) state <= S_OP;
              end
              CMD_TICK: begin
                if (|active) begin
                  previous_now <= req.now_ms;
                  roll <= (req.now_ms < previous_now) &&
                          ((previous_now - req.now_ms) > {16'b0, rollover_window});
                end
                first <= 1'b1;
                scn   <= '0;
                bd_v  <= 1'b0;
                ba_v  <= 1'b0;
                rd_v  <= 1'b0;
                state <= S_SCAN;
              end
              default: ;
            endcase
          end
        end
        S_OP: begin
          if (cur.cmd == CMD_REFRESH) begin
            state <= S_IDLE;
          end else if (cur.period_ms == rd.period && !cur.rearm_now) begin
            state <= S_IDLE;
          end else if (!active[cur_idx]) begin
            state <= S_IDLE;
          end else begin
            bd_rec <= rd.recurring;
            if (cur.rearm_now)                start_r <= cur.now_ms;
            else if (rd.deadline >= {16'b0, rd.period})
              start_r <= rd.deadline - {16'b0, rd.period};
            else                              start_r <= '0;
            state <= S_RST2;
          end
        end
        S_RST2: begin
          state <= S_IDLE;
        end
        S_SCAN: begin
          // issue reads in slot order
          if (scn < (IDX_W + 1)'(NUSE)) begin
            rd_v   <= 1'b1;
            rd_idx <= scn[IDX_W-1:0];
            scn    <= scn + (IDX_W + 1)'(1);
          end else begin
            rd_v <= 1'b0;
          end
          // compare the entry read back
          if (rd_v) begin
            if (first) due[rd_idx] <= rd_due;
            if (rd_due && (!bd_v || rd.deadline < bd_dl)) begin
              bd_v   <= 1'b1;
              bd_idx <= rd_idx;
              bd_dl  <= rd.deadline;
              bd_per <= rd.period;
              bd_rec <= rd.recurring;
            end
            if (active[rd_idx] && (!ba_v || rd.deadline < ba_dl)) begin
              ba_v  <= 1'b1;
              ba_dl <= rd.deadline;
            end
            if (rd_idx == LAST_IDX) state <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (bd_v) begin
            due[bd_idx]  <= 1'b0;
            if (!bd_rec) active[bd_idx] <= 1'b0;
            first <= 1'b0;
            scn   <= '0;
            bd_v  <= 1'b0;
            ba_v  <= 1'b0;
            rd_v  <= 1'b0;
            state <= S_SCAN;
          end else begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // a result that is not the last one of a request leaves the block busy
  a_more_results: assert property (@(posedge clk) disable iff (rst)
    done && !rsp.last |-> busy) else $error("busy dropped before last result");

  // every accepted request leads to a result or a busy block next cycle
  a_progress: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy || done) else $error("request lost");

  // expiry results only come from a tick and are never final
  a_expiry: assert property (@(posedge clk) disable iff (rst)
    done && rsp.expired |-> !rsp.last && rsp.status == ST_OK && cur.cmd == CMD_TICK)
    else $error("bad expiry result");

  // the scan only reads back entries while in the scan state
  a_scan_read: assert property (@(posedge clk) disable iff (rst)
    rd_v && state == S_SCAN |-> $past(state) == S_SCAN)
    else $error("stray scan read");

endmodule

>>> verif/tb_deadline_timer_table.sv
`timescale 1ns / 100ps
// Testbench for deadline_timer_table: random and directed timer requests,
// checked against a scoreboard that predicts every result. Needs dtt_pkg.
module tb_deadline_timer_table;
  import dtt_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [47:0] NOW_MAX = {48{1'b1}};
  localparam logic [31:0] P_MAX = {32{1'b1}};

  // Timer table predictor plus queue of expected results
  class timer_scoreboard;
    bit act[32];
    bit rec[32];
    bit written[32];
    logic [31:0] per[32];
    logic [47:0] dl[32];
    logic [47:0] prev_now;
    logic [31:0] roll_win;
    logic [31:0] idle_wait;
    rsp_t exp_q[$];
    int errors;

    function new();
      roll_win = ROLLOVER_RESET;
      idle_wait = IDLE_WAIT_RESET;
      prev_now = '0;
      errors = 0;
      foreach (act[i]) begin
        act[i] = 0; rec[i] = 0; written[i] = 0; per[i] = '0; dl[i] = '0;
      end
    endfunction

    function logic [47:0] add_sat(logic [47:0] a, logic [31:0] b);
      logic [48:0] s;
      s = {1'b0, a} + {17'b0, b};
      return s[48] ? NOW_MAX : s[47:0];
    endfunction

    function void push(logic [1:0] st, logic [4:0] sl, bit ex, logic [31:0] w, bit lst);
      rsp_t r;
      r.status = st; r.out_slot = sl; r.expired = ex; r.wait_ms = w; r.last = lst;
      exp_q.insert(exp_q.size(), r);
    endfunction

    function void set_cfg(logic idx, logic [31:0] val);
      if (idx == CFG_ROLLOVER) roll_win = val;
      else idle_wait = val;
    endfunction

    // Work out the results of one accepted request
    function void note_request(req_t q);
      int best;
      bit roll, any;
      bit due[32];
      logic [47:0] strt;
      logic [47:0] d;
      logic [31:0] w;
      case (q.cmd)
        CMD_ADD: begin
          best = -1;
          for (int i = 0; i < 32; i++)
            if (best < 0 && !act[i]) best = i;
          if (best < 0) push(ST_FULL, 0, 0, 0, 1);
          else begin
            act[best] = 1; rec[best] = q.repeats; per[best] = q.period_ms;
            dl[best] = add_sat(q.now_ms, q.period_ms); written[best] = 1;
            push(ST_OK, best[4:0], 0, 0, 1);
          end
        end
        CMD_CANCEL, CMD_REFRESH: begin
          if (!act[q.slot]) push(ST_INACTIVE, 0, 0, 0, 1);
          else begin
            if (q.cmd == CMD_CANCEL) act[q.slot] = 0;
            else dl[q.slot] = add_sat(q.now_ms, per[q.slot]);
            push(ST_OK, 0, 0, 0, 1);
          end
        end
        CMD_RESET: begin
          if (q.period_ms == per[q.slot] && !q.rearm_now) push(ST_OK, 0, 0, 0, 1);
          else if (!act[q.slot]) push(ST_INACTIVE, 0, 0, 0, 1);
          else begin
            if (q.rearm_now) strt = q.now_ms;
            else strt = (dl[q.slot] >= {16'b0, per[q.slot]}) ?
                        dl[q.slot] - {16'b0, per[q.slot]} : '0;
            per[q.slot] = q.period_ms;
            dl[q.slot] = add_sat(strt, q.period_ms);
            push(ST_OK, 0, 0, 0, 1);
          end
        end
        CMD_TICK: begin
          any = 0;
          foreach (act[i]) if (act[i]) any = 1;
          if (any) begin
            roll = (q.now_ms < prev_now) && ((prev_now - q.now_ms) > {16'b0, roll_win});
            prev_now = q.now_ms;
            foreach (due[i]) due[i] = act[i] && (roll || dl[i] <= q.now_ms);
            // expiries in deadline order, lower slot first on ties
            forever begin
              best = -1;
              for (int i = 0; i < 32; i++)
                if (due[i] && (best < 0 || dl[i] < dl[best])) best = i;
              if (best < 0) break;
              due[best] = 0;
              push(ST_OK, best[4:0], 1, 0, 0);
              if (rec[best]) dl[best] = add_sat(q.now_ms, per[best]);
              else act[best] = 0;
            end
          end
          best = -1;
          for (int i = 0; i < 32; i++)
            if (act[i] && (best < 0 || dl[i] < dl[best])) best = i;
          if (best < 0) w = idle_wait;
          else if (q.now_ms >= dl[best]) w = '0;
          else begin
            d = dl[best] - q.now_ms;
            w = (d > {16'b0, P_MAX}) ? P_MAX : d[31:0];
          end
          push(ST_OK, 0, 0, w, 1);
        end
        default: push(ST_OK, 0, 0, 0, 1);
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(rsp_t r);
      rsp_t e;
      if (exp_q.size() == 0) begin
        report_mismatch("result with no request outstanding");
        return;
      end
      e = exp_q.pop_front();
      if (r.status !== e.status)
        report_mismatch($sformatf("status %0d, want %0d", r.status, e.status));
      if (r.out_slot !== e.out_slot)
        report_mismatch($sformatf("out_slot %0d, want %0d", r.out_slot, e.out_slot));
      if (r.expired !== e.expired)
        report_mismatch($sformatf("expired %0d, want %0d", r.expired, e.expired));
      if (r.wait_ms !== e.wait_ms)
        report_mismatch($sformatf("wait_ms %0d, want %0d", r.wait_ms, e.wait_ms));
      if (r.last !== e.last)
        report_mismatch($sformatf("last %0d, want %0d", r.last, e.last));
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic start = 0;
  logic busy;
  req_t req = '0;
  logic done;
  rsp_t rsp;
  logic cfg_we = 0;
  logic cfg_index = 0;
  logic [31:0] cfg_data = '0;

  timer_scoreboard sb = new();
  int idle_pct = 0;
  int quiet_cycles = 0;
  logic [47:0] cur_now = '0;

  always #10 clk = ~clk;

  deadline_timer_table uut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Result monitor and watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (done) sb.check_result(rsp);
      if (done || (start && !busy)) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("Watchdog timeout");
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Drive one request and hold it until taken
  task send(req_t q);
    while ($urandom_range(99) < idle_pct) begin
      @(negedge clk);
      start <= 0;
    end
    @(negedge clk);
    start <= 1;
    req <= q;
    do @(posedge clk); while (busy);
    sb.note_request(q);
  endtask

  function req_t mk(logic [2:0] c, logic [47:0] n, logic [4:0] s, logic [31:0] p,
                    bit rp, bit fn);
    req_t q;
    q.cmd = c; q.now_ms = n; q.slot = s; q.period_ms = p; q.repeats = rp; q.rearm_now = fn;
    return q;
  endfunction

  // Drain, then write a register while the block is idle
  task write_cfg(logic idx, logic [31:0] val);
    @(negedge clk);
    start <= 0;
    while (sb.exp_q.size() != 0 || busy) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_cfg(idx, val);
  endtask

  // One random request, mostly well-formed timer traffic
  task send_random();
    int pick;
    logic [2:0] c;
    logic [4:0] s;
    logic [31:0] p;
    pick = $urandom_range(99);
    if (pick < 3) cur_now = cur_now - {16'b0, $urandom()};
    else if (pick < 5) cur_now = 48'({$urandom(), $urandom()});
    else cur_now = cur_now + $urandom_range(0, 300);
    pick = $urandom_range(99);
    if (pick < 35) c = CMD_TICK;
    else if (pick < 60) c = CMD_ADD;
    else if (pick < 70) c = CMD_CANCEL;
    else if (pick < 80) c = CMD_REFRESH;
    else if (pick < 95) c = CMD_RESET;
    else c = 3'($urandom_range(5, 7));
    s = 5'($urandom_range(0, 31));
    pick = $urandom_range(9);
    p = (pick == 0) ? $urandom() : (pick == 1) ? 32'd0 : $urandom_range(0, 500);
    if (c == CMD_RESET) begin
      // only reset slots that have held a timer
      if (!sb.written[s]) begin
        c = CMD_CANCEL;
        foreach (sb.written[i]) if (sb.written[i]) begin c = CMD_RESET; s = 5'(i); end
      end
      if ($urandom_range(3) == 0) p = sb.per[s];
    end
    send(mk(c, cur_now, s, p, 1'($urandom_range(1)), 1'($urandom_range(1))));
  endtask

  initial begin
    repeat (5) @(negedge clk);
    rst <= 0;

    // Directed: extremes, every command, rollover
    send(mk(CMD_TICK, 0, 0, 0, 0, 0));
    send(mk(CMD_CANCEL, 0, 5, 0, 0, 0));
    send(mk(CMD_REFRESH, 0, 31, 0, 0, 0));
    send(mk(CMD_ADD, 0, 0, 0, 1, 0));
    send(mk(CMD_ADD, 0, 0, P_MAX, 0, 0));
    send(mk(CMD_ADD, NOW_MAX, 31, P_MAX, 1, 1));
    send(mk(CMD_ADD, 10, 0, 20, 0, 0));
    send(mk(CMD_TICK, 10, 0, 0, 0, 0));
    send(mk(CMD_RESET, 15, 3, 20, 0, 0));
    send(mk(CMD_RESET, 15, 3, 40, 0, 0));
    send(mk(CMD_RESET, 20, 3, 5, 0, 1));
    send(mk(CMD_REFRESH, 21, 3, 0, 0, 0));
    send(mk(CMD_TICK, 30, 0, 0, 0, 0));
    send(mk(CMD_TICK, NOW_MAX, 0, 0, 0, 0));
    send(mk(CMD_TICK, 0, 0, 0, 0, 0));
    send(mk(CMD_CANCEL, 0, 1, 0, 0, 0));
    send(mk(3'd5, NOW_MAX, 31, P_MAX, 1, 1));
    send(mk(3'd7, 0, 0, 0, 0, 0));
    send(mk(CMD_RESET, 40, 1, 0, 0, 1));
    send(mk(CMD_TICK, 50, 0, 0, 0, 0));

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: begin idle_pct = 72; write_cfg(CFG_ROLLOVER, 0); write_cfg(CFG_IDLE_WAIT, 0); end
        2: begin idle_pct = 6; write_cfg(CFG_ROLLOVER, P_MAX); write_cfg(CFG_IDLE_WAIT, P_MAX); end
        default: begin
          idle_pct = 0;
          write_cfg(CFG_ROLLOVER, $urandom_range(0, 2000));
          write_cfg(CFG_IDLE_WAIT, $urandom());
        end
      endcase
      // fill the table past full, then tick just after and jump back to zero
      if (ph == 2) begin
        for (int i = 0; i < 33; i++)
          send(mk(CMD_ADD, cur_now, 0, $urandom_range(100, 5000),
                  1'($urandom_range(1)), 0));
        send(mk(CMD_TICK, cur_now + 1, 0, 0, 0, 0));
        send(mk(CMD_TICK, 0, 0, 0, 0, 0));
        cur_now = 0;
      end
      for (int k = 0; k < 29; k++) send_random();
    end

    @(negedge clk);
    start <= 0;
    while (sb.exp_q.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
